>>> hdl/riag_pkg.sv
`default_nettype none
package riag_pkg;

    localparam int VIEW_WIDTH  = 320;
    localparam int VIEW_HEIGHT = 240;
    localparam int MAP_WIDTH   = 1024;
    localparam int MAP_HEIGHT  = 1024;

    localparam int COL_W   = $clog2(VIEW_WIDTH);
    localparam int ROW_W   = $clog2(VIEW_HEIGHT);
    localparam int MAP_X_W = $clog2(MAP_WIDTH);
    localparam int MAP_Y_W = $clog2(MAP_HEIGHT);

    localparam int POS_W       = 32;
    localparam int FRAC_W      = 8;
    localparam int STEP_W      = 10;
    localparam int CENTER_W    = 18;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 18;
    localparam int MAP_IDX_W   = 20;
    localparam int FRAME_IDX_W = 17;

    localparam int ROUND_HALF   = 128;
    localparam int COS_RESET    = 256;
    localparam int SIN_RESET    = 0;
    localparam int CENTER_RESET = 131072;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS      = 2'd0,
        CFG_SIN      = 2'd1,
        CFG_CENTER_X = 2'd2,
        CFG_CENTER_Y = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic signed [STEP_W-1:0] cos_value;
        logic signed [STEP_W-1:0] sin_value;
        logic [CENTER_W-1:0]      center_x;
        logic [CENTER_W-1:0]      center_y;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             eol;
        logic             eof;
    } t_pos;

endpackage
`default_nettype wire

>>> hdl/rotated_image_address_generator_top.sv
`default_nettype none
// Rotated view address generator: each accepted word advances one pixel of the
// VIEW_WIDTH x VIEW_HEIGHT view in raster order (restart high returns to pixel
// zero) and yields the map index to sample plus the framebuffer index to write.
// One word per clock cycle sustained while the output is not stalled by i_ready;
// each word passes through the input register, then the position accumulator
// stage, then the address register. The rate is set by the position
// accumulator, which adds the cos/sin step or reloads the rotated row start.
// Configuration writes take effect for the next pixel or row start.
module rotated_image_address_generator_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_restart,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [riag_pkg::MAP_IDX_W-1:0]        o_map_index,
    output logic [riag_pkg::FRAME_IDX_W-1:0]      o_frame_index,
    output logic                                  o_outside_map,
    output logic                                  o_end_of_line,
    output logic                                  o_end_of_frame,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [riag_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [riag_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import riag_pkg::*;

    t_cfg cfg;
    t_pos pos;

    logic r_in_valid;
    logic r_restart;
    logic r_s_valid;
    logic r_o_valid;
    logic ready_o, ready_s, ready_in;
    logic fire_s, fire_o;

    assign ready_o  = !r_o_valid || i_ready;
    assign ready_s  = !r_s_valid || ready_o;
    assign ready_in = !r_in_valid || ready_s;
    assign fire_s   = r_in_valid && ready_s;
    assign fire_o   = r_s_valid && ready_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_s_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (ready_in) begin
                r_in_valid <= i_valid;
            end
            if (ready_s) begin
                r_s_valid <= r_in_valid;
            end
            if (ready_o) begin
                r_o_valid <= r_s_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_in && i_valid) begin
            r_restart <= i_restart;
        end
    end

    riag_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_write (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    riag_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire_s),
        .i_restart (r_restart),
        .i_cfg     (cfg),
        .o_pos     (pos)
    );

    riag_addr u_addr (
        .i_clk          (i_clk),
        .i_load         (fire_o),
        .i_pos          (pos),
        .o_map_index    (o_map_index),
        .o_frame_index  (o_frame_index),
        .o_outside_map  (o_outside_map),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_frame (o_end_of_frame)
    );

    assign o_ready     = ready_in;
    assign o_valid     = r_o_valid;
    assign o_cfg_ready = 1'b1;

    a_eof_is_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_frame |-> o_end_of_line)
        else $error("frame end without line end");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outside_map |-> (o_map_index == '0))
        else $error("outside sample with nonzero map index");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid && !ready_o |=> r_s_valid && $stable(pos))
        else $error("position stage lost or changed a stalled word");

endmodule
`default_nettype wire

>>> hdl/riag_cfg.sv
`default_nettype none
module riag_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_write,
    input  wire logic [riag_pkg::CFG_IDX_W-1:0]   i_index,
    input  wire logic [riag_pkg::CFG_DATA_W-1:0]  i_data,
    output riag_pkg::t_cfg                        o_cfg
);
    import riag_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_value <= STEP_W'(COS_RESET);
            r_cfg.sin_value <= STEP_W'(SIN_RESET);
            r_cfg.center_x  <= CENTER_W'(CENTER_RESET);
            r_cfg.center_y  <= CENTER_W'(CENTER_RESET);
        end else if (i_write) begin
            unique case (t_cfg_reg'(i_index))
                CFG_COS:      r_cfg.cos_value <= i_data[STEP_W-1:0];
                CFG_SIN:      r_cfg.sin_value <= i_data[STEP_W-1:0];
                CFG_CENTER_X: r_cfg.center_x  <= i_data[CENTER_W-1:0];
                CFG_CENTER_Y: r_cfg.center_y  <= i_data[CENTER_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> hdl/riag_step.sv
`default_nettype none
module riag_step (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire logic        i_restart,
    input  wire riag_pkg::t_cfg i_cfg,
    output riag_pkg::t_pos   o_pos
);
    import riag_pkg::*;

    localparam logic signed [COL_W:0] X_START = (COL_W+1)'(-(VIEW_WIDTH / 2));

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_sx, n_sx;
    logic [POS_W-1:0] r_sy, n_sy;
    t_pos             r_pos, n_pos;

    logic [ROW_W-1:0]              cur_row;
    logic [COL_W-1:0]              cur_col;
    logic signed [ROW_W:0]         ys;
    logic signed [STEP_W+COL_W:0]  c_xs, s_xs;
    logic signed [STEP_W+ROW_W:0]  c_ys, s_ys;
    logic [POS_W-1:0]              start_x, start_y;
    logic                          eol, eof;

    always_comb begin
        cur_row = i_restart ? '0 : r_row;
        cur_col = i_restart ? '0 : r_col;

        // rotate the row's left corner, then translate and round
        ys   = signed'({1'b0, cur_row} - (ROW_W+1)'(VIEW_HEIGHT / 2));
        c_xs = i_cfg.cos_value * X_START;
        s_xs = i_cfg.sin_value * X_START;
        c_ys = i_cfg.cos_value * ys;
        s_ys = i_cfg.sin_value * ys;
        start_x = POS_W'(c_xs) - POS_W'(s_ys) + POS_W'(i_cfg.center_x) + POS_W'(ROUND_HALF);
        start_y = POS_W'(s_xs) + POS_W'(c_ys) + POS_W'(i_cfg.center_y) + POS_W'(ROUND_HALF);

        eol = (cur_col == COL_W'(VIEW_WIDTH - 1));
        eof = eol && (cur_row == ROW_W'(VIEW_HEIGHT - 1));

        n_pos.x   = (cur_col == '0) ? start_x : r_sx;
        n_pos.y   = (cur_col == '0) ? start_y : r_sy;
        n_pos.row = cur_row;
        n_pos.col = cur_col;
        n_pos.eol = eol;
        n_pos.eof = eof;

        n_sx = n_pos.x + POS_W'(i_cfg.cos_value);
        n_sy = n_pos.y + POS_W'(i_cfg.sin_value);

        if (eol) begin
            n_col = '0;
            n_row = eof ? '0 : cur_row + 1'b1;
        end else begin
            n_col = cur_col + 1'b1;
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
        end else if (i_fire) begin
            r_row <= n_row;
            r_col <= n_col;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < COL_W'(VIEW_WIDTH))
        else $error("column count out of range");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row < ROW_W'(VIEW_HEIGHT))
        else $error("row count out of range");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && eof |=> (r_row == '0) && (r_col == '0))
        else $error("walk did not wrap to pixel zero after frame end");

endmodule
`default_nettype wire

>>> hdl/riag_addr.sv
`default_nettype none
module riag_addr (
    input  wire logic                              i_clk,
    input  wire logic                              i_load,
    input  wire riag_pkg::t_pos                    i_pos,
    output logic [riag_pkg::MAP_IDX_W-1:0]         o_map_index,
    output logic [riag_pkg::FRAME_IDX_W-1:0]       o_frame_index,
    output logic                                   o_outside_map,
    output logic                                   o_end_of_line,
    output logic                                   o_end_of_frame
);
    import riag_pkg::*;

    localparam int HI_W = POS_W - 1 - FRAC_W;

    logic [MAP_IDX_W-1:0]   r_map_index, n_map_index;
    logic [FRAME_IDX_W-1:0] r_frame_index, n_frame_index;
    logic                   r_outside, n_outside;
    logic                   r_eol, r_eof;
    logic [MAP_X_W-1:0]     px;
    logic [MAP_Y_W-1:0]     py;

    always_comb begin
        px = i_pos.x[FRAC_W +: MAP_X_W];
        py = i_pos.y[FRAC_W +: MAP_Y_W];
        n_outside = i_pos.x[POS_W-1] || i_pos.y[POS_W-1]
                 || (i_pos.x[POS_W-2:FRAC_W] >= HI_W'(MAP_WIDTH))
                 || (i_pos.y[POS_W-2:FRAC_W] >= HI_W'(MAP_HEIGHT));
        n_map_index = n_outside ? '0
                    : MAP_IDX_W'(py) * MAP_IDX_W'(MAP_WIDTH) + MAP_IDX_W'(px);
        n_frame_index = FRAME_IDX_W'(i_pos.row) * FRAME_IDX_W'(VIEW_WIDTH)
                      + FRAME_IDX_W'(i_pos.col);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_map_index   <= n_map_index;
            r_frame_index <= n_frame_index;
            r_outside     <= n_outside;
            r_eol         <= i_pos.eol;
            r_eof         <= i_pos.eof;
        end
    end

    assign o_map_index    = r_map_index;
    assign o_frame_index  = r_frame_index;
    assign o_outside_map  = r_outside;
    assign o_end_of_line  = r_eol;
    assign o_end_of_frame = r_eof;

endmodule
`default_nettype wire

>>> dv/tb.sv
`default_nettype none
module tb;
    import riag_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_MAX    = 10;
    localparam int PHASE_WORDS   = 100;

    typedef struct packed {
        logic [MAP_IDX_W-1:0]   map_index;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   outside_map;
        logic                   end_of_line;
        logic                   end_of_frame;
    } t_pixel_addr;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic                   i_restart = 1'b0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [MAP_IDX_W-1:0]   o_map_index;
    logic [FRAME_IDX_W-1:0] o_frame_index;
    logic                   o_outside_map;
    logic                   o_end_of_line;
    logic                   o_end_of_frame;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_COS;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // predicted block state
    int          cos_step = COS_RESET;
    int          sin_step = SIN_RESET;
    int          center_x = CENTER_RESET;
    int          center_y = CENTER_RESET;
    int          row_cnt = 0;
    int          col_cnt = 0;
    logic [31:0] pos_x = '0;
    logic [31:0] pos_y = '0;

    logic        pending_restart[$];
    t_pixel_addr addr_due[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int words_sent = 0;
    int addrs_checked = 0;
    int mismatches = 0;
    int outside_seen = 0;
    int eol_seen = 0;
    int eof_seen = 0;
    int reg_writes = 0;
    int stall_cycles = 0;

    rotated_image_address_generator_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_restart      (i_restart),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_map_index    (o_map_index),
        .o_frame_index  (o_frame_index),
        .o_outside_map  (o_outside_map),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_frame (o_end_of_frame),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_pixel_addr step_pixel(logic restart);
        t_pixel_addr r;
        int          ys;
        logic [31:0] px;
        logic [31:0] py;
        if (restart) begin
            row_cnt = 0;
            col_cnt = 0;
        end
        if (col_cnt == 0) begin
            ys = row_cnt - VIEW_HEIGHT / 2;
            pos_x = cos_step * -(VIEW_WIDTH / 2) - sin_step * ys + center_x + ROUND_HALF;
            pos_y = sin_step * -(VIEW_WIDTH / 2) + cos_step * ys + center_y + ROUND_HALF;
        end
        px = pos_x >> FRAC_W;
        py = pos_y >> FRAC_W;
        r.outside_map = pos_x[31] || pos_y[31] || px >= MAP_WIDTH || py >= MAP_HEIGHT;
        r.map_index = r.outside_map ? '0 : MAP_IDX_W'(py * MAP_WIDTH + px);
        r.frame_index = FRAME_IDX_W'(row_cnt * VIEW_WIDTH + col_cnt);
        r.end_of_line = col_cnt == VIEW_WIDTH - 1;
        r.end_of_frame = r.end_of_line && row_cnt == VIEW_HEIGHT - 1;
        pos_x = pos_x + cos_step;
        pos_y = pos_y + sin_step;
        col_cnt++;
        if (col_cnt == VIEW_WIDTH) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt == VIEW_HEIGHT) begin
                row_cnt = 0;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                addr_due.push_back(step_pixel(i_restart));
                words_sent++;
            end
            if (!i_valid || o_ready) begin
                if (pending_restart.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_restart <= pending_restart.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_pixel_addr got;
        t_pixel_addr want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = '{o_map_index, o_frame_index, o_outside_map, o_end_of_line,
                        o_end_of_frame};
                addrs_checked++;
                outside_seen += got.outside_map;
                eol_seen += got.end_of_line;
                eof_seen += got.end_of_frame;
                if (addr_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("unexpected word: map %h frame %0d", got.map_index,
                                 got.frame_index);
                    end
                end else begin
                    want = addr_due.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("word %0d: expected map %h frame %0d out %b eol %b eof %b",
                                     addrs_checked, want.map_index, want.frame_index,
                                     want.outside_map, want.end_of_line, want.end_of_frame);
                            $display("    got map %h frame %0d out %b eol %b eof %b",
                                     got.map_index, got.frame_index, got.outside_map,
                                     got.end_of_line, got.end_of_frame);
                        end
                    end
                end
            end
            i_ready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // call at a rising edge; leaves the write channel valid
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        case (idx)
            CFG_COS:      cos_step = $signed(data[STEP_W-1:0]);
            CFG_SIN:      sin_step = $signed(data[STEP_W-1:0]);
            CFG_CENTER_X: center_x = data[CENTER_W-1:0];
            CFG_CENTER_Y: center_y = data[CENTER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(int cos_v, int sin_v, int cx, int cy);
        logic [CFG_DATA_W-STEP_W-1:0] junk_c;
        logic [CFG_DATA_W-STEP_W-1:0] junk_s;
        junk_c = $urandom;
        junk_s = $urandom;
        @(posedge i_clk);
        write_reg(CFG_COS, {junk_c, cos_v[STEP_W-1:0]});
        write_reg(CFG_SIN, {junk_s, sin_v[STEP_W-1:0]});
        write_reg(CFG_CENTER_X, cx[CFG_DATA_W-1:0]);
        write_reg(CFG_CENTER_Y, cy[CFG_DATA_W-1:0]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_restart.size() != 0 || i_valid || addr_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic int rand_step();
        case ($urandom_range(7))
            0:       return -256;
            1:       return 256;
            2:       return int'($urandom_range(1023)) - 512;
            default: return int'($urandom_range(512)) - 256;
        endcase
    endfunction

    function automatic int rand_center();
        case ($urandom_range(5))
            0:       return 0;
            1:       return (1 << CENTER_W) - 1;
            default: return int'($urandom_range((1 << CENTER_W) - 1));
        endcase
    endfunction

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        idle_tab = '{0, 78, 0, 30};
        stall_tab = '{0, 0, 78, 30};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        pending_restart = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
        wait_idle();
        configure(-256, 256, 0, 0);
        @(negedge i_clk);
        pending_restart = '{1'b1, 1'b0, 1'b0, 1'b0};
        wait_idle();
        configure(256, -256, (1 << CENTER_W) - 1, (1 << CENTER_W) - 1);
        @(negedge i_clk);
        pending_restart = '{1'b1, 1'b0, 1'b0};
        wait_idle();
        configure(-512, 511, CENTER_RESET, (1 << CENTER_W) - 1);
        @(negedge i_clk);
        pending_restart = '{1'b1, 1'b0};
        wait_idle();
        configure(0, 0, 200000, 5000);
        @(negedge i_clk);
        pending_restart = '{1'b1, 1'b0};
        wait_idle();

        // walk past two row ends into the third row
        configure(181, -181, CENTER_RESET, 140000);
        @(negedge i_clk);
        pending_restart.push_back(1'b1);
        repeat (2 * VIEW_WIDTH + 5) pending_restart.push_back(1'b0);
        wait_idle();

        for (int m = 0; m < 4; m++) begin
            for (int k = 0; k < 2; k++) begin
                configure(rand_step(), rand_step(), rand_center(), rand_center());
                @(negedge i_clk);
                send_idle_pct = idle_tab[m];
                recv_stall_pct = stall_tab[m];
                repeat (PHASE_WORDS) pending_restart.push_back($urandom_range(99) < (k ? 15 : 2));
                wait_idle();
            end
        end

        mismatches += addr_due.size();
        $display("%0d pixels sent, %0d addresses checked, %0d register writes",
                 words_sent, addrs_checked, reg_writes);
        $display("outside samples %0d, row ends %0d, frame ends %0d, mismatches %0d",
                 outside_seen, eol_seen, eof_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
hdl/riag_pkg.sv
hdl/riag_cfg.sv
hdl/riag_step.sv
hdl/riag_addr.sv
hdl/rotated_image_address_generator_top.sv
dv/tb.sv
